>>> rtl/cprgb_pkg.sv
`timescale 1ns / 1ps

package cprgb_pkg;

	localparam int SAMPLE_BITS_DEF  = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 30;

	// Samples sit at bit 60 - SAMPLE_BITS, so the top of the datapath is fixed.
	localparam int SCALE_TOP = 60;
	localparam int XW        = 64;
	localparam int ZW        = 34;
	localparam int LEVEL_W   = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL  = 1'd1;

	localparam logic [LEVEL_W-1:0] HIGH_RESET = 8'd255;
	localparam logic [LEVEL_W-1:0] LOW_RESET  = 8'd50;

	// Phase format: pi = 2^31.
	localparam logic signed [ZW-1:0] PHASE_PI = 34'sh0_8000_0000;

	// round(atan(2^-i) * 2^31 / pi)
	localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} vec_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] high;
		logic [LEVEL_W-1:0] low;
	} levels_t;

endpackage

>>> rtl/cprgb_cordic_stage.sv
`timescale 1ns / 1ps

module cprgb_cordic_stage #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  cprgb_pkg::vec_t in_vec,
	output logic            out_valid,
	input  logic            out_ready,
	output cprgb_pkg::vec_t out_vec
);
	import cprgb_pkg::*;

	localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[STEP]);

	logic signed [XW-1:0] xi, yi, dx, dy;
	vec_t                 nxt;

	assign xi = in_vec.x;
	assign yi = in_vec.y;
	assign dx = yi >>> STEP;
	assign dy = xi >>> STEP;

	always_comb begin
		nxt      = in_vec;
		if (!yi[XW-1]) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = in_vec.z + ANGLE;
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = in_vec.z - ANGLE;
		end
	end

	assign in_ready = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			out_vec <= nxt;
		end
	end

endmodule

>>> rtl/cprgb_cordic.sv
`timescale 1ns / 1ps

module cprgb_cordic #(
	parameter int SAMPLE_BITS  = cprgb_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = cprgb_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_BITS-1:0]       real_part,
	input  logic signed [SAMPLE_BITS-1:0]       imag_part,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [cprgb_pkg::ZW-1:0]     phase
);
	import cprgb_pkg::*;

	localparam int GUARD  = SCALE_TOP - SAMPLE_BITS;
	localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	logic signed [XW-1:0] re_w, im_w;
	vec_t                 pre;
	vec_t                 vec_s1;
	logic                 valid_s1, rdy_s1;

	vec_t                 chain_vec [NSTEPS+1];
	logic [NSTEPS:0]      chain_valid, chain_ready;

	logic signed [ZW-1:0] z_end, z_sat;
	logic signed [ZW-1:0] phase_s3;
	logic                 valid_s3, rdy_s3;

	// Scale up and turn left-half vectors by pi so x starts nonnegative.
	assign re_w = XW'(real_part) <<< GUARD;
	assign im_w = XW'(imag_part) <<< GUARD;

	always_comb begin
		pre.zero = (real_part == '0) && (imag_part == '0);
		if (re_w[XW-1]) begin
			pre.x = -re_w;
			pre.y = -im_w;
			pre.z = im_w[XW-1] ? -PHASE_PI : PHASE_PI;
		end else begin
			pre.x = re_w;
			pre.y = im_w;
			pre.z = '0;
		end
	end

	assign rdy_s1   = !valid_s1 || chain_ready[0];
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			vec_s1 <= pre;
		end
	end

	assign chain_vec[0]   = vec_s1;
	assign chain_valid[0] = valid_s1;

	for (genvar k = 0; k < NSTEPS; k++) begin : g_step
		cprgb_cordic_stage #(
			.STEP(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[k]),
			.in_ready (chain_ready[k]),
			.in_vec   (chain_vec[k]),
			.out_valid(chain_valid[k+1]),
			.out_ready(chain_ready[k+1]),
			.out_vec  (chain_vec[k+1])
		);
	end

	// Saturate the residue to [-pi, pi]; force zero samples to phase 0.
	assign z_end = chain_vec[NSTEPS].z;

	always_comb begin
		if (chain_vec[NSTEPS].zero) begin
			z_sat = '0;
		end else if (z_end > PHASE_PI) begin
			z_sat = PHASE_PI;
		end else if (z_end < -PHASE_PI) begin
			z_sat = -PHASE_PI;
		end else begin
			z_sat = z_end;
		end
	end

	assign rdy_s3              = !valid_s3 || out_ready;
	assign chain_ready[NSTEPS] = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= chain_valid[NSTEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && chain_valid[NSTEPS]) begin
			phase_s3 <= z_sat;
		end
	end

	assign out_valid = valid_s3;
	assign phase     = phase_s3;

	a_prerot_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !vec_s1.x[XW-1])
		else $error("pre-rotation left x negative");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (phase_s3 <= PHASE_PI) && (phase_s3 >= -PHASE_PI))
		else $error("phase outside [-pi, pi]");

endmodule

>>> rtl/cprgb_hue.sv
`timescale 1ns / 1ps

module cprgb_hue (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [cprgb_pkg::ZW-1:0]       phase,
	input  cprgb_pkg::levels_t                    levels,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cprgb_pkg::LEVEL_W-1:0]         red,
	output logic [cprgb_pkg::LEVEL_W-1:0]         green,
	output logic [cprgb_pkg::LEVEL_W-1:0]         blue
);
	import cprgb_pkg::*;

	localparam int TW = ZW;
	localparam int UW = 32;
	localparam int PW = LEVEL_W + UW;
	localparam int CW = LEVEL_W + 2;
	localparam logic [UW-1:0] U_MAX = 32'h8000_0000;

	typedef enum logic [2:0] {
		SEG_GREEN_UP,
		SEG_RED_DOWN,
		SEG_BLUE_UP,
		SEG_NEG_BLUE_UP,
		SEG_NEG_RED_DOWN,
		SEG_NEG_GREEN_UP
	} seg_t;

	logic signed [TW-1:0] t, p1, p2;
	seg_t                 seg_w;
	logic signed [TW-1:0] u_w;

	seg_t                 seg_s1, seg_s2;
	logic [UW-1:0]        u_s1;
	logic [LEVEL_W-1:0]   q_s2;
	logic                 neg_s2;
	logic [LEVEL_W-1:0]   red_s3, green_s3, blue_s3;
	logic                 valid_s1, valid_s2, valid_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;

	logic signed [LEVEL_W:0] r;
	logic [LEVEL_W-1:0]      mag;
	logic [PW-1:0]           prod;

	logic signed [CW-1:0] ramp, hi, lo, up, down;
	logic signed [CW-1:0] rc, gc, bc;

	// Stage 1: t = 3 * phase, pick the wheel segment and the ramp distance.
	assign p1 = TW'(PHASE_PI);
	assign p2 = p1 <<< 1;
	assign t  = phase + (phase <<< 1);

	always_comb begin
		if (!t[TW-1] && t <= p1) begin
			seg_w = SEG_GREEN_UP;
			u_w   = t;
		end else if (!t[TW-1] && t <= p2) begin
			seg_w = SEG_RED_DOWN;
			u_w   = t - p1;
		end else if (!t[TW-1]) begin
			seg_w = SEG_BLUE_UP;
			u_w   = t - p2;
		end else if (t > -p1) begin
			seg_w = SEG_NEG_BLUE_UP;
			u_w   = -t;
		end else if (t > -p2) begin
			seg_w = SEG_NEG_RED_DOWN;
			u_w   = -t - p1;
		end else begin
			seg_w = SEG_NEG_GREEN_UP;
			u_w   = -t - p2;
		end
	end

	// Stage 2: |r| * u / pi, sign of r kept aside for truncation toward zero.
	assign r    = $signed({1'b0, levels.high}) - $signed({1'b0, levels.low});
	assign mag  = r[LEVEL_W] ? LEVEL_W'(-r) : LEVEL_W'(r);
	assign prod = PW'(mag) * PW'(u_s1);

	// Stage 3: place ramp and levels on the three channels.
	assign ramp = neg_s2 ? -$signed(CW'(q_s2)) : $signed(CW'(q_s2));
	assign hi   = $signed(CW'(levels.high));
	assign lo   = $signed(CW'(levels.low));
	assign up   = lo + ramp;
	assign down = hi - ramp;

	always_comb begin
		unique case (seg_s2)
			SEG_GREEN_UP:     begin rc = hi;   gc = up;   bc = lo;   end
			SEG_RED_DOWN:     begin rc = down; gc = hi;   bc = lo;   end
			SEG_BLUE_UP:      begin rc = lo;   gc = hi;   bc = up;   end
			SEG_NEG_BLUE_UP:  begin rc = hi;   gc = lo;   bc = up;   end
			SEG_NEG_RED_DOWN: begin rc = down; gc = lo;   bc = hi;   end
			SEG_NEG_GREEN_UP: begin rc = lo;   gc = up;   bc = hi;   end
			default:          begin rc = lo;   gc = lo;   bc = lo;   end
		endcase
	end

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			seg_s1 <= seg_w;
			u_s1   <= UW'(u_w);
		end
		if (rdy_s2 && valid_s1) begin
			seg_s2 <= seg_s1;
			q_s2   <= prod[UW+LEVEL_W-2:UW-1];
			neg_s2 <= r[LEVEL_W];
		end
		if (rdy_s3 && valid_s2) begin
			red_s3   <= rc[LEVEL_W-1:0];
			green_s3 <= gc[LEVEL_W-1:0];
			blue_s3  <= bc[LEVEL_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign red       = red_s3;
	assign green     = green_s3;
	assign blue      = blue_s3;

	a_ramp_span: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (u_s1 <= U_MAX))
		else $error("ramp distance exceeds one segment");

endmodule

>>> rtl/complex_phase_to_rgb.sv
`timescale 1ns / 1ps

// Phase-to-color mapper for domain coloring of a streamed complex image.
// The input channel (in_valid / in_ready) takes one word per cycle while
// in_ready is high: the signed real and imaginary parts of a sample. The
// phase is found by a CORDIC arctangent in vectoring mode, one iteration
// per pipeline stage, then placed on a six-segment hue wheel. The output
// channel (out_valid / out_ready) returns one word per sample: red, green,
// blue. Throughput: one word per cycle, sustained while the receiver keeps
// up, set by the fully unrolled CORDIC pipe. Each word passes the registered
// pre-rotation, CORDIC step, saturation, hue segment, ramp and channel stages.
// Each stage has its own valid bit and stalls only when occupied and its
// successor is full, so bubbles squeeze out and the block keeps taking
// words while a finished result waits in the output register. When the
// receiver stalls the pipe fills and in_ready drops; nothing is lost.
// Reset clears every valid bit and loads high_level = 255, low_level = 50.
// cfg_we writes register cfg_index (0 high level, 1 low level) with
// cfg_data at once; write only while no word is in flight.
module complex_phase_to_rgb #(
	parameter int SAMPLE_BITS  = cprgb_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = cprgb_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_BITS-1:0]        real_part,
	input  logic signed [SAMPLE_BITS-1:0]        imag_part,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cprgb_pkg::LEVEL_W-1:0]        red_level,
	output logic [cprgb_pkg::LEVEL_W-1:0]        green_level,
	output logic [cprgb_pkg::LEVEL_W-1:0]        blue_level,
	input  logic                                 cfg_we,
	input  logic [cprgb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cprgb_pkg::LEVEL_W-1:0]        cfg_data
);
	import cprgb_pkg::*;

	logic [LEVEL_W-1:0]   high_q, low_q;
	levels_t              levels;
	logic signed [ZW-1:0] phase;
	logic                 phase_valid, phase_ready;

	// Level registers: take a write whenever the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= HIGH_RESET;
			low_q  <= LOW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HIGH_LEVEL: high_q <= cfg_data;
				CFG_LOW_LEVEL:  low_q  <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign levels.high = high_q;
	assign levels.low  = low_q;

	// Phase pipe: pre-rotation, one stage per CORDIC step, saturation.
	cprgb_cordic #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.real_part(real_part),
		.imag_part(imag_part),
		.out_valid(phase_valid),
		.out_ready(phase_ready),
		.phase    (phase)
	);

	// Hue wheel: segment pick, ramp multiply, channel assembly.
	cprgb_hue u_hue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (phase_valid),
		.in_ready (phase_ready),
		.phase    (phase),
		.levels   (levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red      (red_level),
		.green    (green_level),
		.blue     (blue_level)
	);

	// An empty output register must open the whole pipe to new words.
	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipe refused a word with an empty output register");

endmodule

>>> tb/tb_complex_phase_to_rgb.sv
`timescale 1ns / 1ps

module tb_complex_phase_to_rgb;
	import cprgb_pkg::*;

	localparam int SB       = SAMPLE_BITS_DEF;
	localparam int STEPS    = CORDIC_STEPS_DEF;
	localparam int GUARD    = SCALE_TOP - SB;
	localparam int LUT_LEN  = 30;
	localparam longint HALF_TURN = longint'(1) <<< 31;

	// atan(2^-i) scaled so that pi = 2^31, rounded
	localparam longint ARCTAN_LUT [LUT_LEN] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304,
		652, 326, 163, 81, 41,
		20, 10, 5, 3, 1
	};

	// Points on the sixty degree spokes of the wheel, in thousandths.
	localparam int SPOKE_COS [6] = '{1000, 500, -500, -1000, -500, 500};
	localparam int SPOKE_SIN [6] = '{0, 866, 866, 0, -866, -866};
	localparam int EDGE_VALS [6] = '{-32768, -32767, -1, 0, 1, 32767};

	typedef logic signed [SB-1:0] sample_t;
	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} pixel_t;

	// Tracks the levels the block holds and the colors still owed by it.
	class color_book;
		pixel_t             pending [$];
		int unsigned        faults;
		logic [LEVEL_W-1:0] hi_lvl;
		logic [LEVEL_W-1:0] lo_lvl;

		function new();
			faults = 0;
			hi_lvl = HIGH_RESET;
			lo_lvl = LOW_RESET;
		endfunction

		// trunc(r * u / pi) with u >= 0, toward zero
		function longint wheel_ramp(longint r, longint u);
			longint q;
			q = ((r < 0) ? -r : r) * u / HALF_TURN;
			return (r < 0) ? -q : q;
		endfunction

		// Run the vectoring CORDIC on one sample, then place the phase on the wheel.
		function void note_sample(sample_t re, sample_t im);
			longint x, y, z, dx, dy, t, h, l, r, p, rd, gr, bl;
			pixel_t px;
			x = longint'(re) <<< GUARD;
			y = longint'(im) <<< GUARD;
			z = 0;
			if (re != 0 || im != 0) begin
				// left half plane: turn by pi first
				if (x < 0) begin
					z = (y >= 0) ? HALF_TURN : -HALF_TURN;
					x = -x;
					y = -y;
				end
				for (int i = 0; i < STEPS && i < LUT_LEN; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (y >= 0) begin
						x += dx;
						y -= dy;
						z += ARCTAN_LUT[i];
					end else begin
						x -= dx;
						y += dy;
						z -= ARCTAN_LUT[i];
					end
				end
				// clamp the residue back into [-pi, pi]
				if (z > HALF_TURN)
					z = HALF_TURN;
				if (z < -HALF_TURN)
					z = -HALF_TURN;
			end
			t = 3 * z;
			h = hi_lvl;
			l = lo_lvl;
			r = h - l;
			p = HALF_TURN;
			if (t >= 0 && t <= p) begin
				rd = h; gr = l + wheel_ramp(r, t); bl = l;
			end else if (t > p && t <= 2 * p) begin
				rd = h - wheel_ramp(r, t - p); gr = h; bl = l;
			end else if (t > 2 * p) begin
				rd = l; gr = h; bl = l + wheel_ramp(r, t - 2 * p);
			end else if (t > -p) begin
				rd = h; gr = l; bl = l + wheel_ramp(r, -t);
			end else if (t > -2 * p) begin
				rd = h - wheel_ramp(r, -t - p); gr = l; bl = h;
			end else begin
				rd = l; gr = l + wheel_ramp(r, -t - 2 * p); bl = h;
			end
			px.red   = LEVEL_W'(rd);
			px.green = LEVEL_W'(gr);
			px.blue  = LEVEL_W'(bl);
			pending = {pending, px};
		endfunction

		function void compare_field(string name, logic [LEVEL_W-1:0] want,
				logic [LEVEL_W-1:0] got);
			if (got !== want) begin
				faults++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_color(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				faults++;
				$display("%0t: color word expected none got %0d %0d %0d", $time,
					got.red, got.green, got.blue);
				return;
			end
			want = pending.pop_front();
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
		endfunction
	endclass

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_ready;
	sample_t              real_part   = '0;
	sample_t              imag_part   = '0;
	logic                 out_valid;
	logic                 out_ready   = 1'b0;
	logic [LEVEL_W-1:0]   red_level;
	logic [LEVEL_W-1:0]   green_level;
	logic [LEVEL_W-1:0]   blue_level;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_HIGH_LEVEL;
	logic [LEVEL_W-1:0]   cfg_data    = '0;

	color_book sb = new();
	int        words_in = 0;
	// set while the receiver is in its long hold-off; the sender drops its gaps then
	bit        long_hold = 1'b0;

	complex_phase_to_rgb uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.real_part  (real_part),
		.imag_part  (imag_part),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_level  (red_level),
		.green_level(green_level),
		.blue_level (blue_level),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Sample both handshakes at the edge. Every input changes by nonblocking
	// assignment and every output follows registers or inputs, so the values seen here
	// are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.note_sample(real_part, imag_part);
			words_in++;
		end
		if (arst_n && out_valid && out_ready)
			sb.check_color('{red_level, green_level, blue_level});
	end

	// Offer one word and hold it until the block takes it.
	task automatic push_sample(input sample_t re, input sample_t im);
		in_valid  <= 1'b1;
		real_part <= re;
		imag_part <= im;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Advance until every owed color has come back.
	task automatic wait_idle();
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Send count random words in bursts with random gaps. The mix leans on the
	// corners of the wheel: small vectors, the axes, the spokes at multiples of
	// sixty degrees (segment edges), and the extreme codes.
	task automatic stream_mix(input int count);
		int      burst, kind, mag, spoke;
		sample_t re, im, tmp;
		while (count > 0) begin
			burst = $urandom_range(1, 32);
			while (burst > 0 && count > 0) begin
				kind = $urandom_range(0, 99);
				if (kind < 40) begin
					re = sample_t'($urandom);
					im = sample_t'($urandom);
				end else if (kind < 55) begin
					re = sample_t'(int'($urandom_range(0, 16)) - 8);
					im = sample_t'(int'($urandom_range(0, 16)) - 8);
				end else if (kind < 70) begin
					// on or next to an axis; the negative real axis hits the pi clamp
					re = sample_t'($urandom);
					im = sample_t'(int'($urandom_range(0, 2)) - 1);
					if ($urandom_range(0, 1)) begin
						tmp = re;
						re  = im;
						im  = tmp;
					end
				end else if (kind < 90) begin
					mag   = $urandom_range(1, 30000);
					spoke = $urandom_range(0, 5);
					re = sample_t'(mag * SPOKE_COS[spoke] / 1000 +
						int'($urandom_range(0, 4)) - 2);
					im = sample_t'(mag * SPOKE_SIN[spoke] / 1000 +
						int'($urandom_range(0, 4)) - 2);
				end else begin
					re = sample_t'(EDGE_VALS[$urandom_range(0, 5)]);
					im = sample_t'(EDGE_VALS[$urandom_range(0, 5)]);
				end
				push_sample(re, im);
				burst--;
				count--;
			end
			if (!long_hold && count > 0 && $urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 10))
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [LEVEL_W-1:0] hi_set [8];
		logic [LEVEL_W-1:0] lo_set [8];
		// full swing, both at zero, both at full, inverted, a mid pair each way,
		// then two random pairs
		hi_set = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd100, 8'd200, 8'd0, 8'd0};
		lo_set = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd200, 8'd100, 8'd0, 8'd0};
		for (int k = 6; k < 8; k++) begin
			hi_set[k] = LEVEL_W'($urandom);
			lo_set[k] = LEVEL_W'($urandom);
		end

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset levels. Zero gives plain red; the
		// negative real axis starts at pi and must clamp there.
		push_sample(16'sd0, 16'sd0);
		push_sample(16'sd32767, 16'sd0);
		push_sample(-16'sd32768, 16'sd0);
		push_sample(-16'sd1, 16'sd0);
		push_sample(-16'sd32768, -16'sd1);
		push_sample(16'sd0, 16'sd32767);
		push_sample(16'sd0, -16'sd32768);
		push_sample(-16'sd32768, -16'sd32768);
		push_sample(16'sd32767, 16'sd32767);
		push_sample(-16'sd32768, 16'sd32767);
		push_sample(16'sd32767, -16'sd32768);
		push_sample(16'sd1, 16'sd0);
		push_sample(16'sd0, 16'sd1);
		push_sample(16'sd0, -16'sd1);
		push_sample(-16'sd1, -16'sd1);
		push_sample(16'sd1000, 16'sd1732);
		push_sample(-16'sd1000, -16'sd1732);
		stream_mix(150);

		// Each phase: drain, rewrite both levels, stream again.
		for (int k = 0; k < 8; k++) begin
			wait_idle();
			cfg_we    <= 1'b1;
			cfg_index <= CFG_HIGH_LEVEL;
			cfg_data  <= hi_set[k];
			@(posedge clk);
			cfg_index <= CFG_LOW_LEVEL;
			cfg_data  <= lo_set[k];
			@(posedge clk);
			cfg_we    <= 1'b0;
			sb.hi_lvl = hi_set[k];
			sb.lo_lvl = lo_set[k];
			stream_mix(190);
		end

		wait_idle();
		// let any stray word fall out of the pipe
		repeat (STEPS + 8)
			@(posedge clk);
		if (sb.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Receiver: pick a stall mode for a random span, then switch. Once, after a
	// few hundred words, hold off for a long stretch so the pipe fills and
	// in_ready drops while the sender keeps offering.
	initial begin : receiver
		int mode, span, hold_cnt, tick;
		bit held_once;
		held_once = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 200);
			repeat (span) begin
				if (!held_once && words_in >= 300) begin
					held_once = 1'b1;
					long_hold = 1'b1;
					out_ready <= 1'b0;
					for (hold_cnt = 0; hold_cnt < 120; hold_cnt++)
						@(posedge clk);
					long_hold = 1'b0;
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (tick % 7) < 4;
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	// Give up if the run hangs.
	initial begin : watchdog
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
